[rtl/acr_pkg.sv]
`default_nettype none

package acr_pkg;

	// Default sizing of the allocation table.
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int ADDR_BITS_DEF   = 48;

	// Byte totals and milestones are 40 bits wide.
	localparam int TOT_W = 40;
	localparam int SIZE_W = 31;
	localparam logic [TOT_W-1:0] STEP_RESET = 40'd1000000;

	// Operation codes.
	localparam logic [1:0] OP_RECORD  = 2'd0;
	localparam logic [1:0] OP_REALLOC = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_NULL_REC  = 3'd2;
	localparam logic [2:0] ST_OVERLAP   = 3'd3;
	localparam logic [2:0] ST_RA_UNKN   = 3'd4;
	localparam logic [2:0] ST_FREE_NULL = 3'd5;
	localparam logic [2:0] ST_FREE_UNKN = 3'd6;
	localparam logic [2:0] ST_FULL      = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHECK_EN  = 2'd0;
	localparam logic [1:0] CFG_REPORT_EN = 2'd1;
	localparam logic [1:0] CFG_STEP      = 2'd2;

endpackage

`default_nettype wire

[rtl/allocation_range_checker_unit.sv]
// Allocation range checker.
// Input words arrive on the s_axis channel (op, address, new_address, size,
// site_tag, timestamp); one result word per input leaves on m_axis (status,
// conflict_site, conflict_time, total_bytes, milestone_crossed).
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle; the block does not enforce it. The live
// table sits in one RAM, kept sorted by start address. An item is handled
// by a sequencer: a linear search through the RAM (one entry per cycle),
// then a shift of the table by one entry per cycle for an insert or a
// remove, then a total update. When a report milestone is crossed, a
// bit-serial remainder unit finds the next milestone. At most MAX_ENTRIES
// entries are held in the table.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register until taken, and the next word is accepted
// meanwhile; the sequencer waits at its end while that register is full.
// Reset empties the table, clears the total and restores the registers.
`default_nettype none

module allocation_range_checker_unit #(
	parameter int MAX_ENTRIES = acr_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_BITS   = acr_pkg::ADDR_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// op, address, new_address, size, site_tag, timestamp, zero pad
	input  wire logic [((2*ADDR_BITS+105)/8)*8-1:0]    s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// status, conflict_site, conflict_time, total_bytes, milestone_crossed, pad
	output logic      [111:0]                          m_axis_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [acr_pkg::TOT_W-1:0]             cfg_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = acr_pkg::SIZE_W;
	localparam int TW = acr_pkg::TOT_W;
	localparam int EW = ADDR_BITS + SW + 64;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_EVAL, S_RM, S_INS, S_INS_WR, S_ADJ, S_CHK, S_DIV, S_MSET,
		S_DONE
	} state_t;

	state_t state_q, ret_q;

	// Configuration registers.
	logic          chk_en_q, rep_en_q;
	logic [TW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_en_q <= 1'b1;
			rep_en_q <= 1'b0;
			step_q   <= acr_pkg::STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acr_pkg::CFG_CHECK_EN:  chk_en_q <= cfg_data[0];
				acr_pkg::CFG_REPORT_EN: rep_en_q <= cfg_data[0];
				acr_pkg::CFG_STEP:      step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input word fields.
	logic [1:0]           in_op;
	logic [ADDR_BITS-1:0] in_addr, in_na;
	logic [31:0]          in_size;
	logic                 in_bad_size;
	assign in_op       = s_axis_tdata[1:0];
	assign in_addr     = s_axis_tdata[ADDR_BITS+1:2];
	assign in_na       = s_axis_tdata[2*ADDR_BITS+1:ADDR_BITS+2];
	assign in_size     = s_axis_tdata[2*ADDR_BITS+33:2*ADDR_BITS+2];
	assign in_bad_size = (in_size == 32'd0) || in_size[31];

	// Early verdict on a new word before any table access.
	logic [2:0] acc_status;
	logic       acc_scan;
	always_comb begin
		acc_status = acr_pkg::ST_OK;
		acc_scan   = 1'b0;
		if (chk_en_q) begin
			unique case (in_op)
				acr_pkg::OP_RECORD: begin
					if (in_bad_size) begin
						acc_status = acr_pkg::ST_BAD_SIZE;
					end else if (in_addr == '0) begin
						acc_status = acr_pkg::ST_NULL_REC;
					end else begin
						acc_scan = 1'b1;
					end
				end
				acr_pkg::OP_REALLOC: begin
					if (in_bad_size) begin
						acc_status = acr_pkg::ST_BAD_SIZE;
					end else begin
						acc_scan = 1'b1;
					end
				end
				acr_pkg::OP_FREE: begin
					if (in_addr == '0) begin
						acc_status = acr_pkg::ST_FREE_NULL;
					end else begin
						acc_scan = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Item and sequencer registers.
	logic [1:0]           op_q;
	logic [ADDR_BITS-1:0] key_q, na_q;
	logic [SW-1:0]        size_q, amt_q, rm_size_q;
	logic [31:0]          site_q, time_q;
	logic                 second_q, add_q, cnt_cross_q;
	logic [CW-1:0]        count_q, rd_idx_q, pos_q;
	logic                 vld_q;
	logic [IW-1:0]        wa_q;
	logic [EW-1:0]        prev_q, succ_q;
	logic                 have_prev_q, have_succ_q;
	logic [TW-1:0]        total_q, next_ms_q;
	logic [TW:0]          rem_q;
	logic [TW-1:0]        dvd_q;
	logic [5:0]           div_cnt_q;
	logic                 crossed_q;
	logic [2:0]           status_q;
	logic [31:0]          csite_q, ctime_q;
	logic                 m_valid_q;
	logic [111:0]         m_data_q;

	// Table RAM.
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr, ram_raddr;
	logic [EW-1:0]        ram_wdata, ram_rdata;
	logic [CW-1:0]        ins_src;

	assign ins_src = rd_idx_q - 1'b1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = ram_rdata;
		ram_raddr = rd_idx_q[IW-1:0];
		unique case (state_q)
			S_RM: begin
				ram_we = vld_q;
			end
			S_INS: begin
				ram_we    = vld_q;
				ram_raddr = ins_src[IW-1:0];
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = {time_q, site_q, size_q, key_q};
			end
			default: ;
		endcase
	end

	acr_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Search compare and overlap test.
	logic                 rd_below;
	logic [ADDR_BITS-1:0] pred_gap, succ_gap;
	logic                 pred_hit, succ_hit, exact_hit;
	assign rd_below  = ram_rdata[ADDR_BITS-1:0] < key_q;
	assign pred_gap  = key_q - prev_q[ADDR_BITS-1:0];
	assign succ_gap  = succ_q[ADDR_BITS-1:0] - key_q;
	assign pred_hit  = have_prev_q &&
		(64'(prev_q[ADDR_BITS+SW-1:ADDR_BITS]) > 64'(pred_gap));
	assign succ_hit  = have_succ_q && (64'(size_q) > 64'(succ_gap));
	assign exact_hit = have_succ_q && (succ_q[ADDR_BITS-1:0] == key_q);

	// Total update and milestone arithmetic.
	logic [TW:0]   add_sum, div_try, ms_sum;
	logic [TW-1:0] adj_total, step_eff;
	logic          div_ge;
	assign step_eff = (step_q == '0) ? TW'(1) : step_q;
	assign add_sum  = {1'b0, total_q} + (TW+1)'(amt_q);
	always_comb begin
		if (add_q) begin
			adj_total = add_sum[TW] ? '1 : add_sum[TW-1:0];
		end else begin
			adj_total = (TW'(amt_q) > total_q) ? '0 : total_q - TW'(amt_q);
		end
	end
	assign div_try = {rem_q[TW-1:0], dvd_q[TW-1]};
	assign div_ge  = div_try >= {1'b0, step_eff};
	assign ms_sum  = {1'b0, total_q} - rem_q + {1'b0, step_eff};

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_DONE;
			count_q     <= '0;
			total_q     <= '0;
			next_ms_q   <= acr_pkg::STEP_RESET;
			m_valid_q   <= 1'b0;
			vld_q       <= 1'b0;
			rd_idx_q    <= '0;
			have_prev_q <= 1'b0;
			have_succ_q <= 1'b0;
			second_q    <= 1'b0;
			crossed_q   <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q        <= in_op;
						key_q       <= in_addr;
						na_q        <= in_na;
						size_q      <= in_size[SW-1:0];
						site_q      <= s_axis_tdata[2*ADDR_BITS+65:2*ADDR_BITS+34];
						time_q      <= s_axis_tdata[2*ADDR_BITS+97:2*ADDR_BITS+66];
						status_q    <= acc_status;
						csite_q     <= '0;
						ctime_q     <= '0;
						crossed_q   <= 1'b0;
						second_q    <= 1'b0;
						rd_idx_q    <= '0;
						vld_q       <= 1'b0;
						have_prev_q <= 1'b0;
						have_succ_q <= 1'b0;
						state_q     <= acc_scan ? S_SCAN : S_DONE;
					end
				end
				// Walk the table until the first start at or above the key.
				S_SCAN: begin
					if (vld_q && !rd_below) begin
						pos_q       <= ins_src;
						succ_q      <= ram_rdata;
						have_succ_q <= 1'b1;
						vld_q       <= 1'b0;
						state_q     <= S_EVAL;
					end else begin
						if (vld_q) begin
							prev_q      <= ram_rdata;
							have_prev_q <= 1'b1;
						end
						if (rd_idx_q < count_q) begin
							rd_idx_q <= rd_idx_q + 1'b1;
							vld_q    <= 1'b1;
						end else begin
							pos_q   <= rd_idx_q;
							vld_q   <= 1'b0;
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (op_q == acr_pkg::OP_RECORD || second_q) begin
						if (pred_hit || succ_hit) begin
							status_q <= acr_pkg::ST_OVERLAP;
							csite_q  <= pred_hit ? prev_q[EW-33:EW-64] : succ_q[EW-33:EW-64];
							ctime_q  <= pred_hit ? prev_q[EW-1:EW-32] : succ_q[EW-1:EW-32];
							state_q  <= S_DONE;
						end else if (op_q == acr_pkg::OP_RECORD &&
							count_q >= CW'(MAX_ENTRIES)) begin
							status_q <= acr_pkg::ST_FULL;
							state_q  <= S_DONE;
						end else begin
							rd_idx_q <= count_q;
							vld_q    <= 1'b0;
							state_q  <= S_INS;
						end
					end else if (!exact_hit) begin
						status_q <= (op_q == acr_pkg::OP_FREE) ? acr_pkg::ST_FREE_UNKN :
							acr_pkg::ST_RA_UNKN;
						state_q  <= S_DONE;
					end else begin
						rd_idx_q  <= pos_q + 1'b1;
						vld_q     <= 1'b0;
						rm_size_q <= succ_q[ADDR_BITS+SW-1:ADDR_BITS];
						if (op_q == acr_pkg::OP_REALLOC) begin
							site_q      <= succ_q[EW-33:EW-64];
							time_q      <= succ_q[EW-1:EW-32];
							amt_q       <= '0;
							add_q       <= 1'b1;
							cnt_cross_q <= 1'b1;
							ret_q       <= S_RM;
							state_q     <= S_ADJ;
						end else begin
							state_q <= S_RM;
						end
					end
				end
				// Close the gap: copy each entry above the hole down by one.
				S_RM: begin
					if (rd_idx_q < count_q) begin
						wa_q     <= ins_src[IW-1:0];
						rd_idx_q <= rd_idx_q + 1'b1;
						vld_q    <= 1'b1;
					end else begin
						vld_q <= 1'b0;
						if (!vld_q) begin
							count_q     <= count_q - 1'b1;
							amt_q       <= rm_size_q;
							add_q       <= 1'b0;
							cnt_cross_q <= 1'b0;
							state_q     <= S_ADJ;
							if (op_q == acr_pkg::OP_REALLOC) begin
								key_q       <= na_q;
								second_q    <= 1'b1;
								rd_idx_q    <= '0;
								have_prev_q <= 1'b0;
								have_succ_q <= 1'b0;
								ret_q       <= S_SCAN;
							end else begin
								ret_q <= S_DONE;
							end
						end
					end
				end
				// Open a hole: copy each entry at or above it up by one, top first.
				S_INS: begin
					if (rd_idx_q > pos_q) begin
						wa_q     <= rd_idx_q[IW-1:0];
						rd_idx_q <= ins_src;
						vld_q    <= 1'b1;
					end else begin
						vld_q <= 1'b0;
						if (!vld_q) begin
							state_q <= S_INS_WR;
						end
					end
				end
				S_INS_WR: begin
					count_q     <= count_q + 1'b1;
					amt_q       <= size_q;
					add_q       <= 1'b1;
					cnt_cross_q <= 1'b1;
					ret_q       <= S_DONE;
					state_q     <= S_ADJ;
				end
				S_ADJ: begin
					total_q <= adj_total;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rep_en_q && total_q > next_ms_q) begin
						if (cnt_cross_q) begin
							crossed_q <= 1'b1;
						end
						rem_q     <= '0;
						dvd_q     <= total_q;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else begin
						state_q <= ret_q;
					end
				end
				// Remainder of the total by the step, one bit a cycle.
				S_DIV: begin
					rem_q     <= div_ge ? div_try - {1'b0, step_eff} : div_try;
					dvd_q     <= {dvd_q[TW-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 6'(TW - 1)) begin
						state_q <= S_MSET;
					end
				end
				S_MSET: begin
					next_ms_q <= ms_sum[TW] ? '1 : ms_sum[TW-1:0];
					state_q   <= ret_q;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {4'b0, crossed_q, total_q, ctime_q, csite_q, status_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("live count above table depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			($past(state_q) == S_RM || $past(state_q) == S_INS_WR))
		else $error("live count changed outside remove or insert");
	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_RM || state_q == S_INS || state_q == S_INS_WR))
		else $error("table written outside a shift");
`endif

endmodule

`default_nettype wire

[rtl/acr_ram.sv]
`default_nettype none

module acr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[tb/sv/allocation_range_checker_monitor.sv]
`timescale 1ns / 100ps

// Watches both stream channels and the register port of the range checker,
// keeps its own copy of the allocation table and compares every result word.
module allocation_range_checker_monitor (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [199:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [111:0] m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [39:0]  cfg_data,
	output int                errors,
	output int                pending
);
	import acr_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam logic [63:0] TOTAL_MAX = 64'hFF_FFFF_FFFF;

	// Fields from the top bit down, so status lands in the lowest bits.
	typedef struct packed {
		logic        milestone;
		logic [39:0] total;
		logic [31:0] stamp;
		logic [31:0] site;
		logic [2:0]  status;
	} verdict_t;

	// Mirror of the allocation table and the counters.
	logic [47:0] tab_start [TABLE_DEPTH];
	logic [30:0] tab_size [TABLE_DEPTH];
	logic [31:0] tab_site [TABLE_DEPTH];
	logic [31:0] tab_stamp [TABLE_DEPTH];
	int          live;
	logic [63:0] byte_sum;
	logic [63:0] next_mark;
	logic        chk_en;
	logic        rep_en;
	logic [39:0] step_reg;

	verdict_t expected_q[$];

	// Updates the byte total; returns 1 when a milestone is passed.
	function automatic bit bump_total(logic [63:0] amount, bit add);
		logic [63:0] st;
		logic [63:0] q;
		if (add) begin
			byte_sum = (amount > TOTAL_MAX - byte_sum) ? TOTAL_MAX : byte_sum + amount;
		end else begin
			byte_sum = (amount > byte_sum) ? 64'd0 : byte_sum - amount;
		end
		if (!rep_en || byte_sum <= next_mark)
			return 1'b0;
		st = (step_reg == 0) ? 64'd1 : {24'd0, step_reg};
		q = byte_sum / st + 1;
		next_mark = (q > TOTAL_MAX / st) ? TOTAL_MAX : q * st;
		return 1'b1;
	endfunction

	// Count of entries starting below an address.
	function automatic int pos_below(logic [47:0] a);
		int i;
		i = 0;
		while (i < live && tab_start[i] < a)
			i++;
		return i;
	endfunction

	// Overlap with the neighbor below or the one at or above the address.
	function automatic bit collides(int p, logic [47:0] a, logic [63:0] sz, output int hit);
		hit = 0;
		if (p > 0 && {33'd0, tab_size[p-1]} > {16'd0, a - tab_start[p-1]}) begin
			hit = p - 1;
			return 1'b1;
		end
		if (p < live && sz > {16'd0, tab_start[p] - a}) begin
			hit = p;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void drop_entry(int p);
		void'(bump_total({33'd0, tab_size[p]}, 1'b0));
		for (int i = p; i < live - 1; i++) begin
			tab_start[i] = tab_start[i+1];
			tab_size[i] = tab_size[i+1];
			tab_site[i] = tab_site[i+1];
			tab_stamp[i] = tab_stamp[i+1];
		end
		live--;
	endfunction

	function automatic bit add_entry(int p, logic [47:0] a, logic [30:0] sz,
			logic [31:0] site, logic [31:0] stamp);
		for (int i = live; i > p; i--) begin
			tab_start[i] = tab_start[i-1];
			tab_size[i] = tab_size[i-1];
			tab_site[i] = tab_site[i-1];
			tab_stamp[i] = tab_stamp[i-1];
		end
		tab_start[p] = a;
		tab_size[p] = sz;
		tab_site[p] = site;
		tab_stamp[p] = stamp;
		live++;
		return bump_total({33'd0, sz}, 1'b1);
	endfunction

	// Works out the result word for one accepted input word.
	function automatic verdict_t check_allocation(logic [199:0] w);
		logic [1:0]  op;
		logic [47:0] a;
		logic [47:0] na;
		logic [31:0] sz;
		logic [31:0] site;
		logic [31:0] stamp;
		logic [31:0] keep_site;
		logic [31:0] keep_stamp;
		bit          bad_size;
		bit          crossed;
		int          p;
		int          hit;
		verdict_t    v;
		op = w[1:0];
		a = w[49:2];
		na = w[97:50];
		sz = w[129:98];
		site = w[161:130];
		stamp = w[193:162];
		bad_size = (sz == 0) || sz[31];
		crossed = 1'b0;
		v = '0;
		v.status = ST_OK;
		if (chk_en && op == OP_RECORD) begin
			if (bad_size) begin
				v.status = ST_BAD_SIZE;
			end else if (a == 0) begin
				v.status = ST_NULL_REC;
			end else begin
				p = pos_below(a);
				if (collides(p, a, {32'd0, sz}, hit)) begin
					v.status = ST_OVERLAP;
					v.site = tab_site[hit];
					v.stamp = tab_stamp[hit];
				end else if (live >= TABLE_DEPTH) begin
					v.status = ST_FULL;
				end else begin
					crossed = add_entry(p, a, sz[30:0], site, stamp);
				end
			end
		end else if (chk_en && op == OP_REALLOC) begin
			p = pos_below(a);
			if (bad_size) begin
				v.status = ST_BAD_SIZE;
			end else if (!(p < live && tab_start[p] == a)) begin
				v.status = ST_RA_UNKN;
			end else begin
				keep_site = tab_site[p];
				keep_stamp = tab_stamp[p];
				// A zero-byte update can still report a pending milestone.
				crossed = bump_total(64'd0, 1'b1);
				drop_entry(p);
				p = pos_below(na);
				if (collides(p, na, {32'd0, sz}, hit)) begin
					v.status = ST_OVERLAP;
					v.site = tab_site[hit];
					v.stamp = tab_stamp[hit];
				end else begin
					crossed = add_entry(p, na, sz[30:0], keep_site, keep_stamp) || crossed;
				end
			end
		end else if (chk_en && op == OP_FREE) begin
			p = pos_below(a);
			if (a == 0)
				v.status = ST_FREE_NULL;
			else if (!(p < live && tab_start[p] == a))
				v.status = ST_FREE_UNKN;
			else
				drop_entry(p);
		end
		v.total = byte_sum[39:0];
		v.milestone = crossed;
		return v;
	endfunction

	// Results are compared before the new word is predicted.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			live = 0;
			byte_sum = 0;
			next_mark = {24'd0, STEP_RESET};
			chk_en = 1'b1;
			rep_en = 1'b0;
			step_reg = STEP_RESET;
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[107:0];
				if (expected_q.size() == 0) begin
					$display("%0t: result word with none expected: %h", $time, got);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status)
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					if (got.site !== want.site)
						$display("%0t: conflict_site expected %h actual %h",
							$time, want.site, got.site);
					if (got.stamp !== want.stamp)
						$display("%0t: conflict_time expected %h actual %h",
							$time, want.stamp, got.stamp);
					if (got.total !== want.total)
						$display("%0t: total_bytes expected %0d actual %0d",
							$time, want.total, got.total);
					if (got.milestone !== want.milestone)
						$display("%0t: milestone_crossed expected %0d actual %0d",
							$time, want.milestone, got.milestone);
					if (got !== want)
						errors++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(check_allocation(s_axis_tdata));
			pending = expected_q.size();
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHECK_EN: chk_en = cfg_data[0];
					CFG_REPORT_EN: rep_en = cfg_data[0];
					CFG_STEP: step_reg = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/sv/tb_allocation_range_checker_unit.sv]
`timescale 1ns / 100ps

module tb_allocation_range_checker_unit;
	import acr_pkg::*;

	localparam logic [47:0] HEAP_BASE = 48'h1000;
	localparam logic [47:0] FILL_BASE = 48'h4000_0000;
	localparam int SETTLE = 600;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = CFG_CHECK_EN;
	logic [39:0]  cfg_data = '0;
	int           errors;
	int           pending;

	logic         took;
	bit           quiet = 1'b0;
	int           ready_hold = 0;
	logic [47:0]  live_addrs[$];

	allocation_range_checker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	allocation_range_checker_monitor u_monitor (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// Records whether the input word was taken at the last rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= s_axis_tvalid && s_axis_tready;
		end
	end

	// Result side stalls in bursts.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready = 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			ready_hold = $urandom_range(1, 9) - 1;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	// Offers one word and holds it until it is taken.
	task automatic send(logic [1:0] op, logic [47:0] a, logic [47:0] na,
			logic [31:0] sz, logic [31:0] site, logic [31:0] stamp);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, stamp, site, sz, na, a, op};
		do @(negedge clk); while (!took);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [47:0] heap_addr();
		return HEAP_BASE + 48'($urandom_range(0, 300)) * 32;
	endfunction

	// One random word, mostly well-formed traffic on a crowded heap.
	task automatic random_word();
		int          pick;
		int          idx;
		logic [47:0] a;
		logic [47:0] na;
		logic [31:0] sz;
		pick = $urandom_range(0, 99);
		sz = $urandom_range(1, 96);
		if (pick < 45) begin
			a = heap_addr();
			send(OP_RECORD, a, 48'({$urandom, $urandom}), sz, $urandom, $urandom);
			live_addrs.push_back(a);
		end else if (pick < 70 && live_addrs.size() > 0) begin
			idx = $urandom_range(0, live_addrs.size() - 1);
			a = live_addrs[idx];
			na = heap_addr();
			live_addrs[idx] = na;
			send(OP_REALLOC, a, na, sz, $urandom, $urandom);
		end else if (pick < 92 && live_addrs.size() > 0) begin
			idx = $urandom_range(0, live_addrs.size() - 1);
			a = live_addrs[idx];
			live_addrs.delete(idx);
			send(OP_FREE, a, 48'd0, sz, $urandom, $urandom);
		end else begin
			// Noise: any code, full-width fields.
			send(2'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				$urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed cases at reset settings.
		send(OP_RECORD, 48'h2000, 48'd0, 32'd0, 32'd1, 32'd1);
		send(OP_RECORD, 48'h2000, 48'd0, 32'h8000_0000, 32'd1, 32'd1);
		send(OP_RECORD, 48'd0, 48'd0, 32'd16, 32'd1, 32'd1);
		send(OP_RECORD, 48'h1000, 48'd0, 32'd16, 32'hAAAA_5555, 32'h1234_5678);
		send(OP_RECORD, 48'h1000, 48'd0, 32'd4, 32'd2, 32'd2);
		send(OP_RECORD, 48'h1008, 48'd0, 32'd4, 32'd3, 32'd3);
		send(OP_RECORD, 48'h0FF8, 48'd0, 32'd16, 32'd4, 32'd4);
		send(OP_RECORD, 48'h0FF0, 48'd0, 32'd16, 32'd5, 32'd5);
		send(OP_RECORD, 48'hFFFF_FFFF_FFF0, 48'd0, 32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_RECORD, 48'h8000_0000_0000, 48'd0, 32'h7FFF_FFFF, 32'd6, 32'd6);
		send(OP_REALLOC, 48'h1234, 48'h5000, 32'd8, 32'd7, 32'd7);
		send(OP_REALLOC, 48'h1000, 48'h5000, 32'hFFFF_FFFF, 32'd7, 32'd7);
		send(OP_REALLOC, 48'h1000, 48'd0, 32'd8, 32'd8, 32'd8);
		send(OP_REALLOC, 48'd0, 48'h0FF4, 32'd8, 32'd9, 32'd9);
		send(OP_FREE, 48'd0, 48'd0, 32'd1, 32'd0, 32'd0);
		send(OP_FREE, 48'h7777, 48'd0, 32'd1, 32'd0, 32'd0);
		send(OP_FREE, 48'hFFFF_FFFF_FFF0, 48'd0, 32'd1, 32'd0, 32'd0);
		send(2'd3, 48'h3000, 48'h3000, 32'd16, 32'd0, 32'd0);
		send(OP_RECORD, 48'h3000, 48'd0, 32'd16, 32'd10, 32'd10);
		drain();

		// Milestones at the smallest step.
		write_reg(CFG_REPORT_EN, 40'd1);
		write_reg(CFG_STEP, 40'd1);
		repeat (200) random_word();
		drain();

		// Fill the table past its depth, then empty it again.
		write_reg(CFG_STEP, 40'd4096);
		live_addrs.delete();
		for (int i = 0; i < 262; i++)
			send(OP_RECORD, FILL_BASE + 48'(i) * 256, 48'd0, 32'($urandom_range(1, 256)),
				$urandom, $urandom);
		for (int i = 0; i < 262; i++)
			send(OP_FREE, FILL_BASE + 48'(i) * 256, 48'd0, 32'd1, $urandom, $urandom);
		drain();

		// Checking switched off.
		write_reg(CFG_CHECK_EN, 40'd0);
		repeat (60) random_word();
		drain();

		// Largest step, then a random one without idling.
		write_reg(CFG_CHECK_EN, 40'd1);
		write_reg(CFG_STEP, 40'hFF_FFFF_FFFF);
		repeat (150) random_word();
		drain();
		write_reg(CFG_STEP, 40'($urandom_range(1, 5000)));
		write_reg(CFG_REPORT_EN, 40'($urandom_range(0, 1)));
		quiet = 1'b1;
		repeat (200) random_word();
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/acr_pkg.sv
rtl/acr_ram.sv
rtl/allocation_range_checker_unit.sv
tb/sv/allocation_range_checker_monitor.sv
tb/sv/tb_allocation_range_checker_unit.sv
